>>> rtl/core/sqe_pkg.sv
package sqe_pkg;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_SCAN_END,
      S_SCAN_OUT,
      S_RD_N,
      S_RD_P,
      S_PEAK,
      S_DIV,
      S_MUL1,
      S_MUL2,
      S_MUL3,
      S_MUL4,
      S_WR
   } state_type;

   typedef enum logic [1:0] {
      CSR_LEARN_RATE = 2'd0,
      CSR_DISCOUNT   = 2'd1,
      CSR_LEARN_EN   = 2'd2
   } csr_index_type;

   localparam logic [15:0] LEARN_RATE_RST = 16'd45875;
   localparam logic [15:0] DISCOUNT_RST   = 16'd52429;
   localparam logic signed [31:0] SCAN_FLOOR = -32'sd65536000;

   localparam int MUL_AW = 18;
   localparam int MUL_BW = 35;
   localparam int MUL_PW = MUL_AW + MUL_BW;

   // airtime rate in Q1.16, indexed by clamped SF
   function automatic logic [16:0] rate_lut(input logic [3:0] sf);
      logic [16:0] r;
      begin
         r = 17'd2659;
         unique case (sf)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7: r = 17'd65536;
            4'd8:  r = 17'd35477;
            4'd9:  r = 17'd19345;
            4'd10: r = 17'd10636;
            4'd11: r = 17'd5317;
            default: r = 17'd2659;
         endcase
         return r;
      end
   endfunction

   // a mod 6 by conditional subtraction
   function automatic logic [2:0] mod6(input logic [6:0] a);
      logic [7:0] r;
      begin
         r = {1'b0, a};
         if (r >= 8'd96) r = r - 8'd96;
         if (r >= 8'd48) r = r - 8'd48;
         if (r >= 8'd24) r = r - 8'd24;
         if (r >= 8'd12) r = r - 8'd12;
         if (r >= 8'd6)  r = r - 8'd6;
         return r[2:0];
      end
   endfunction

endpackage

>>> rtl/core/sarsa_q_table_engine.sv
// Channel    | Ports                                   | Handshake
// request    | start, busy, req_*                      | taken when start & !busy
// response   | rsp_valid, rsp_*                        | one-cycle strobe, no stall
// config     | csr_we, csr_index, csr_wdata            | written when csr_we
//
// In a choose transaction the row scan reads one table entry per cycle through
// the single read port of the Q memory.
// A report transaction runs the serial divider, then three passes through the shared multiplier.
// After reset a clearing pass zeroes the Q table and peak store, one entry a
// cycle over max(STATES*ACTIONS, NODES) entries, with busy high.
// The response cannot be stalled; a new request may start the cycle it shows.
module sarsa_q_table_engine #(
   parameter int STATES  = 1344,
   parameter int ACTIONS = 96,
   parameter int NODES   = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_kind,
   input  logic [5:0]         req_node,
   input  logic [10:0]        req_state_prev,
   input  logic [6:0]         req_action_prev,
   input  logic [10:0]        req_state_now,
   input  logic [6:0]         req_action_now,
   input  logic [3:0]         req_received_sf,
   input  logic [4:0]         req_received_tx,
   input  logic [15:0]        req_energy_used,
   input  logic [3:0]         req_sent_sf,
   input  logic [7:0]         req_packets_on_air,
   output logic               rsp_valid,
   output logic [6:0]         rsp_chosen_action,
   output logic signed [31:0] rsp_best_value,
   output logic signed [17:0] rsp_reward,
   output logic               rsp_mismatch,
   output logic               rsp_updated,
   output logic signed [31:0] rsp_new_value,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   localparam int QDEPTH = STATES * ACTIONS;
   localparam int AW     = $clog2(QDEPTH);
   localparam int IW     = $clog2(ACTIONS);
   localparam int NW     = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int CDEPTH = (QDEPTH > NODES) ? QDEPTH : NODES;
   localparam int CW     = $clog2(CDEPTH);

   // configuration
   logic [15:0] learn_rate_ff, discount_ff;
   logic        learn_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         learn_rate_ff <= sqe_pkg::LEARN_RATE_RST;
         discount_ff   <= sqe_pkg::DISCOUNT_RST;
         learn_en_ff   <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            sqe_pkg::CSR_LEARN_RATE: learn_rate_ff <= csr_wdata;
            sqe_pkg::CSR_DISCOUNT:   discount_ff   <= csr_wdata;
            sqe_pkg::CSR_LEARN_EN:   learn_en_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   sqe_pkg::state_type state_ff, state_in;
   logic [CW-1:0] clr_ff, clr_in;
   logic          accept;

   assign busy   = state_ff != sqe_pkg::S_IDLE;
   assign accept = start && !busy;

   // transaction context
   logic [AW-1:0] base_ff, addr_p_ff, addr_n_ff;
   logic          row_ok_ff, p_ok_ff, n_ok_ff, upd_ok_ff, mis_ff;
   logic [NW-1:0] node_idx_ff;
   logic          node_ok_ff;
   logic [15:0]   energy_ff;
   logic [16:0]   drate_ff;

   // scan pipeline
   logic [IW-1:0]       idx_ff, cmp_idx_ff;
   logic                cmp_vld_ff, hit_ff;
   logic signed [31:0]  top_ff, v0_ff;
   logic [IW-1:0]       act_ff;
   logic signed [31:0]  scan_v;

   // report datapath
   logic signed [31:0]  qn_ff, qp_ff;
   logic [16:0]         prate_ff;
   logic                peak_zero_ff;
   logic signed [17:0]  reward_ff, reward_in;
   logic signed [34:0]  td_ff, td_in;
   logic signed [31:0]  g;
   logic [16:0]         prod;
   logic signed [37:0]  nv_wide;
   logic signed [31:0]  nv;

   // memories
   logic signed [31:0]  qmem [QDEPTH];
   logic [15:0]         pmem [NODES];
   logic signed [31:0]  rd_data_ff;
   logic [AW-1:0]       rd_addr, wr_addr;
   logic                q_we;
   logic signed [31:0]  wr_data;
   logic [15:0]         pk_q_ff, pk_max, peak_use;
   logic                pk_we;
   logic [NW-1:0]       pk_addr;
   logic [15:0]         pk_wdata;

   // shared units
   logic signed [sqe_pkg::MUL_AW-1:0] mul_a;
   logic signed [sqe_pkg::MUL_BW-1:0] mul_b;
   logic signed [sqe_pkg::MUL_PW-1:0] mul_p;
   logic        div_start, div_done;
   logic [16:0] div_quo;

   sqe_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p_ff  (mul_p)
   );

   sqe_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num     ({energy_ff, 16'd0}),
      .den     (peak_use),
      .done_ff (div_done),
      .quo     (div_quo)
   );

   // accept-time decode
   logic       req_mis;
   logic [2:0] an_m6;
   logic [5:0] tx_sum;
   logic [3:0] sf_clamp;

   always_comb begin
      an_m6    = sqe_pkg::mod6(req_action_now);
      tx_sum   = {1'b0, req_received_tx} + {1'b0, req_action_now[2:0], 1'b0} + 6'd2;
      req_mis  = (5'd7 + {2'b0, an_m6}) != {1'b0, req_received_sf} || tx_sum != 6'd16;
      sf_clamp = req_sent_sf;
      if (req_sent_sf < 4'd7)  sf_clamp = 4'd7;
      if (req_sent_sf > 4'd12) sf_clamp = 4'd12;
   end

   // peak handling
   always_comb begin
      pk_max   = (energy_ff > pk_q_ff) ? energy_ff : pk_q_ff;
      peak_use = node_ok_ff ? pk_max : energy_ff;
   end

   // scan compare; out-of-table rows read as zero
   assign scan_v = row_ok_ff ? rd_data_ff : 32'sd0;

   // arithmetic taps of the multiplier
   always_comb begin
      prod      = mul_p[32:16];
      reward_in = mis_ff ? -$signed({1'b0, prod}) : $signed({1'b0, drate_ff}) -
                  $signed({1'b0, prod});
      g         = $signed(mul_p[47:16]);
      td_in     = 35'(reward_ff) + 35'(g) - 35'(qp_ff);
      nv_wide   = 38'(qp_ff) + 38'($signed(mul_p[52:16]));
      if (nv_wide > 38'sd2147483647)
         nv = 32'sh7fffffff;
      else if (nv_wide < -38'sd2147483648)
         nv = 32'sh80000000;
      else
         nv = 32'(nv_wide);
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      rd_addr   = base_ff + AW'(idx_ff);
      q_we      = 1'b0;
      wr_addr   = addr_p_ff;
      wr_data   = nv;
      pk_we     = 1'b0;
      pk_addr   = node_idx_ff;
      pk_wdata  = energy_ff;
      div_start = 1'b0;
      mul_a     = $signed({1'b0, drate_ff});
      mul_b     = $signed({18'd0, prate_ff});
      unique case (state_ff)
         sqe_pkg::S_CLEAR: begin
            clr_in   = clr_ff + CW'(1);
            q_we     = 32'(clr_ff) < QDEPTH;
            wr_addr  = AW'(clr_ff);
            wr_data  = 32'sd0;
            pk_we    = 32'(clr_ff) < NODES;
            pk_addr  = NW'(clr_ff);
            pk_wdata = 16'd0;
            if (32'(clr_ff) == CDEPTH - 1) state_in = sqe_pkg::S_IDLE;
         end
         sqe_pkg::S_IDLE: begin
            if (accept) state_in = req_kind ? sqe_pkg::S_RD_N : sqe_pkg::S_SCAN;
         end
         sqe_pkg::S_SCAN: begin
            if (idx_ff == IW'(ACTIONS - 1)) state_in = sqe_pkg::S_SCAN_END;
         end
         sqe_pkg::S_SCAN_END: state_in = sqe_pkg::S_SCAN_OUT;
         sqe_pkg::S_SCAN_OUT: state_in = sqe_pkg::S_IDLE;
         sqe_pkg::S_RD_N: begin
            rd_addr  = addr_n_ff;
            state_in = sqe_pkg::S_RD_P;
         end
         sqe_pkg::S_RD_P: begin
            rd_addr   = addr_p_ff;
            pk_we     = node_ok_ff && (energy_ff > pk_q_ff);
            div_start = 1'b1;
            state_in  = sqe_pkg::S_PEAK;
         end
         sqe_pkg::S_PEAK: state_in = sqe_pkg::S_DIV;
         sqe_pkg::S_DIV: begin
            if (div_done) state_in = sqe_pkg::S_MUL1;
         end
         sqe_pkg::S_MUL1: state_in = sqe_pkg::S_MUL2;
         sqe_pkg::S_MUL2: begin
            mul_a    = $signed({2'b0, discount_ff});
            mul_b    = 35'(qn_ff);
            state_in = sqe_pkg::S_MUL3;
         end
         sqe_pkg::S_MUL3: state_in = sqe_pkg::S_MUL4;
         sqe_pkg::S_MUL4: begin
            mul_a    = $signed({2'b0, learn_rate_ff});
            mul_b    = td_ff;
            state_in = sqe_pkg::S_WR;
         end
         sqe_pkg::S_WR: begin
            q_we     = upd_ok_ff;
            state_in = sqe_pkg::S_IDLE;
         end
         default: state_in = sqe_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sqe_pkg::S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // memory ports
   always_ff @(posedge clock) begin
      if (q_we) qmem[wr_addr] <= wr_data;
      rd_data_ff <= qmem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (pk_we) pmem[pk_addr] <= pk_wdata;
      pk_q_ff <= pmem[node_idx_ff];
   end

   // context and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff <= 1'b0;
         rsp_valid  <= 1'b0;
      end else begin
         cmp_vld_ff <= state_ff == sqe_pkg::S_SCAN;
         rsp_valid  <= state_ff == sqe_pkg::S_SCAN_OUT || state_ff == sqe_pkg::S_WR;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         base_ff     <= AW'(32'(req_state_now) * ACTIONS);
         addr_n_ff   <= AW'(32'(req_state_now) * ACTIONS + 32'(req_action_now));
         addr_p_ff   <= AW'(32'(req_state_prev) * ACTIONS + 32'(req_action_prev));
         row_ok_ff   <= 32'(req_state_now) < STATES;
         n_ok_ff     <= 32'(req_state_now) < STATES && 32'(req_action_now) < ACTIONS;
         p_ok_ff     <= 32'(req_state_prev) < STATES && 32'(req_action_prev) < ACTIONS;
         upd_ok_ff   <= req_packets_on_air > 8'd1 && learn_en_ff;
         mis_ff      <= req_mis;
         node_idx_ff <= NW'(req_node);
         node_ok_ff  <= 32'(req_node) < NODES;
         energy_ff   <= req_energy_used;
         drate_ff    <= sqe_pkg::rate_lut(sf_clamp);
         idx_ff      <= '0;
         top_ff      <= sqe_pkg::SCAN_FLOOR;
         hit_ff      <= 1'b0;
         act_ff      <= '0;
      end
      if (state_ff == sqe_pkg::S_SCAN) idx_ff <= idx_ff + IW'(1);
      cmp_idx_ff <= idx_ff;
      if (cmp_vld_ff) begin
         if (cmp_idx_ff == '0) v0_ff <= scan_v;
         if (scan_v > top_ff) begin
            top_ff <= scan_v;
            act_ff <= cmp_idx_ff;
            hit_ff <= 1'b1;
         end
      end
      if (state_ff == sqe_pkg::S_RD_P) begin
         qn_ff        <= n_ok_ff ? rd_data_ff : 32'sd0;
         peak_zero_ff <= peak_use == 16'd0;
         upd_ok_ff    <= upd_ok_ff && p_ok_ff;
      end
      if (state_ff == sqe_pkg::S_PEAK) qp_ff <= rd_data_ff;
      if (state_ff == sqe_pkg::S_DIV && div_done)
         prate_ff <= peak_zero_ff ? 17'd0 : div_quo;
      if (state_ff == sqe_pkg::S_MUL2) reward_ff <= reward_in;
      if (state_ff == sqe_pkg::S_MUL3) td_ff <= td_in;
      if (state_ff == sqe_pkg::S_SCAN_OUT) begin
         rsp_chosen_action <= 7'(act_ff);
         rsp_best_value    <= hit_ff ? top_ff : v0_ff;
         rsp_reward        <= 18'sd0;
         rsp_mismatch      <= 1'b0;
         rsp_updated       <= 1'b0;
         rsp_new_value     <= 32'sd0;
      end
      if (state_ff == sqe_pkg::S_WR) begin
         rsp_chosen_action <= 7'd0;
         rsp_best_value    <= 32'sd0;
         rsp_reward        <= reward_ff;
         rsp_mismatch      <= mis_ff;
         rsp_updated       <= upd_ok_ff;
         rsp_new_value     <= upd_ok_ff ? nv : 32'sd0;
      end
   end

`ifndef ASSERT_OFF
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == sqe_pkg::S_WR || state_ff == sqe_pkg::S_SCAN_OUT))
      else $error("response strobe without a finishing state");

   a_reward_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_reward >= -18'sd65536 && rsp_reward <= 18'sd65536))
      else $error("reward out of range");

   a_div_to_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sqe_pkg::S_DIV && div_done) |=> state_ff == sqe_pkg::S_MUL1)
      else $error("divider completion not followed by multiply");
`endif

endmodule

>>> rtl/core/sqe_mul.sv
module sqe_mul (
   input  logic                               clock,
   input  logic signed [sqe_pkg::MUL_AW-1:0]  a,
   input  logic signed [sqe_pkg::MUL_BW-1:0]  b,
   output logic signed [sqe_pkg::MUL_PW-1:0]  p_ff
);

   logic signed [sqe_pkg::MUL_PW-1:0] p_in;

   assign p_in = sqe_pkg::MUL_PW'(a) * sqe_pkg::MUL_PW'(b);

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

endmodule

>>> rtl/core/sqe_div.sv
module sqe_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] num,
   input  logic [15:0] den,
   output logic        done_ff,
   output logic [16:0] quo
);

   logic [31:0] num_ff, num_in;
   logic [15:0] rem_ff, rem_in, den_ff;
   logic [5:0]  cnt_ff, cnt_in;
   logic        done_in;
   logic [16:0] trial;
   logic        ge;

   // restoring divide, one quotient bit per cycle shifted into num_ff
   always_comb begin
      trial   = {rem_ff, num_ff[31]};
      ge      = trial >= {1'b0, den_ff};
      num_in  = num_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         num_in = num;
         rem_in = '0;
         cnt_in = 6'd32;
      end else if (cnt_ff != 6'd0) begin
         num_in  = {num_ff[30:0], ge};
         rem_in  = ge ? 16'(trial - {1'b0, den_ff}) : trial[15:0];
         cnt_in  = cnt_ff - 6'd1;
         done_in = cnt_ff == 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      if (start) den_ff <= den;
   end

   assign quo = num_ff[16:0];

endmodule
